// File: design/lift_motor_position_and_homing_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Lift motor sequencer assertion macros
// Shorthand for clocked implication checks on clk, disabled during reset but for LMP_ASSERT_NXT_RST.
// ----------------------------------------------------------------------------
`ifndef LIFT_MOTOR_POSITION_AND_HOMING_SEQUENCER_MACROS_SVH
`define LIFT_MOTOR_POSITION_AND_HOMING_SEQUENCER_MACROS_SVH

// same-cycle implication
`define LMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define LMP_ASSERT_NXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmp_pkg
// Codes, state encodings and helpers of the lift motor sequencer.
// ----------------------------------------------------------------------------
package lmp_pkg;

  // command field
  localparam logic [2:0] CMD_NONE       = 3'd0;
  localparam logic [2:0] CMD_MOVE_START = 3'd1;
  localparam logic [2:0] CMD_MOVE_STOP  = 3'd2;
  localparam logic [2:0] CMD_TEST_START = 3'd3;
  localparam logic [2:0] CMD_TEST_STOP  = 3'd4;
  localparam logic [2:0] CMD_DRV_ON     = 3'd5;
  localparam logic [2:0] CMD_DRV_OFF    = 3'd6;

  // move part motor command
  localparam logic [1:0] MC_NONE = 2'd0;
  localparam logic [1:0] MC_STOP = 2'd1;
  localparam logic [1:0] MC_MOVE = 2'd2;

  // test part motor command
  localparam logic [1:0] TC_NONE = 2'd0;
  localparam logic [1:0] TC_STOP = 2'd1;
  localparam logic [1:0] TC_FAST = 2'd2;
  localparam logic [1:0] TC_SLOW = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_STALL   = 2'd2;
  localparam logic [1:0] ERR_LIMIT   = 2'd3;

  // reported move phase
  localparam logic [1:0] MS_IDLE   = 2'd0;
  localparam logic [1:0] MS_MOVING = 2'd1;
  localparam logic [1:0] MS_SETTLE = 2'd2;

  // direction
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // delays in ticks
  localparam logic [7:0] DLY_SHORT = 8'd5;
  localparam logic [7:0] DLY_LONG  = 8'd50;

  // reset register values
  localparam logic [15:0] TIMEOUT_RST = 16'd3000;
  localparam logic [15:0] SPEED_RST   = 16'd300;

  typedef enum logic [2:0] {
    MV_IDLE   = 3'b001,
    MV_MOVING = 3'b010,
    MV_SETTLE = 3'b100
  } move_st_t;

  typedef enum logic [6:0] {
    TS_IDLE = 7'b0000001,
    TS_WAIT = 7'b0000010,
    TS_UP   = 7'b0000100,
    TS_DOWN = 7'b0001000,
    TS_HOLD = 7'b0010000,
    TS_SLOW = 7'b0100000,
    TS_DONE = 7'b1000000
  } test_st_t;

  function automatic logic [1:0] move_code(input move_st_t st);
    logic [1:0] c;
    case (st)
      MV_IDLE:   c = MS_IDLE;
      MV_MOVING: c = MS_MOVING;
      MV_SETTLE: c = MS_SETTLE;
      default:   c = MS_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] test_code(input test_st_t st);
    logic [2:0] c;
    case (st)
      TS_IDLE: c = 3'd0;
      TS_WAIT: c = 3'd1;
      TS_UP:   c = 3'd2;
      TS_DOWN: c = 3'd3;
      TS_HOLD: c = 3'd4;
      TS_SLOW: c = 3'd5;
      TS_DONE: c = 3'd6;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

// File: design/lmp_step_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmp_step_calc
// Direction and step count of a positioned move: |dest - pos| * 25 / 64,
// saturated to 16 bits.
// ----------------------------------------------------------------------------
module lmp_step_calc
  import lmp_pkg::*;
(
  input  logic signed [31:0] pos,
  input  logic signed [31:0] dest,
  output logic               differ,
  output logic               down,
  output logic        [15:0] steps
);

  logic [32:0] diff;
  logic [31:0] mag;
  logic [36:0] prod;

  assign diff   = {pos[31], pos} - {dest[31], dest};
  assign down   = (pos > dest) ? DIR_DOWN : DIR_UP;
  assign differ = (pos != dest);
  assign mag    = down ? diff[31:0] : 32'(-diff);
  // x25 = x16 + x8 + x1
  assign prod   = {1'b0, mag, 4'b0} + {2'b0, mag, 3'b0} + {5'b0, mag};
  assign steps  = (prod[36:22] != '0) ? 16'hFFFF : prod[21:6];

endmodule

// File: design/lift_motor_position_and_homing_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lift_motor_position_and_homing_sequencer
// Lift motor supervisor: positioned moves, homing and self-test sequence,
// 10 ms tick handling, APB register port.
// ----------------------------------------------------------------------------
//  channel | handshake                 | word
//  in      | in_valid / in_stall       | control pass or tick
//  out     | out_valid / out_stall     | motor commands and status
//  cfg     | psel penable pwrite pready| timeout_ticks @0, test_speed @4
//
//  Accepted words pass from the input register through the sequencer logic
//  and step calculator into the result register, one per cycle unless stalled.
//  in_stall rises only while a result waits under out_stall and the input
//  register is full. Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module lift_motor_position_and_homing_sequencer
  import lmp_pkg::*;
#(
  parameter int RUN_TICK_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic               in_up_level,
  input  logic               in_up_rise,
  input  logic               in_low_level,
  input  logic               in_low_rise,
  input  logic               in_low_fall,
  input  logic               in_motor_running,
  input  logic               in_motor_fault,
  input  logic signed [31:0] in_encoder_pos,
  input  logic               in_speed_zero,
  input  logic        [2:0]  in_command,
  input  logic signed [31:0] in_target_pos,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [1:0]  out_move_cmd,
  output logic        [1:0]  out_test_cmd,
  output logic               out_direction,
  output logic        [15:0] out_step_count,
  output logic               out_encoder_clear,
  output logic               out_driver_on,
  output logic        [1:0]  out_move_state,
  output logic        [2:0]  out_test_state,
  output logic        [1:0]  out_error_code,
  output logic signed [31:0] out_position_report,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam int CMP_W = (RUN_TICK_BITS > 16) ? RUN_TICK_BITS : 16;
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_SPEED   = 1'b1;

  typedef struct packed {
    logic        func;
    logic        up_level;
    logic        up_rise;
    logic        low_level;
    logic        low_rise;
    logic        low_fall;
    logic        running;
    logic        fault;
    logic [31:0] pos;
    logic        szero;
    logic [2:0]  cmd;
    logic [31:0] target;
  } word_t;

  typedef struct packed {
    logic [1:0]  mcmd;
    logic [1:0]  tcmd;
    logic        dir;
    logic [15:0] steps;
    logic        clr;
    logic        drv;
    logic [1:0]  mstate;
    logic [2:0]  tstate;
    logic [1:0]  err;
    logic [31:0] pos;
  } res_t;

  // handshake
  logic  s1_valid_r, s1_valid_nxt;
  word_t s1_r;
  logic  out_valid_r, out_valid_nxt;
  res_t  res_r, res_nxt;
  logic  in_take, s1_adv;

  // registers
  logic [15:0] timeout_r, speed_r;
  logic        cfg_wr;

  // sequencer state
  move_st_t                 move_ph_r, move_ph_nxt;
  test_st_t                 test_ph_r, test_ph_nxt;
  logic                     move_en_r, move_en_nxt;
  logic                     test_en_r, test_en_nxt;
  logic                     drv_want_r, drv_want_nxt;
  logic                     drv_state_r, drv_state_nxt;
  logic [7:0]               delay_r, delay_nxt;
  logic [RUN_TICK_BITS-1:0] run_ticks_r, run_ticks_nxt;
  logic [1:0]               err_r, err_nxt;
  logic [31:0]              goal_r, goal_nxt;
  logic [31:0]              sampled_r, sampled_nxt;
  logic                     up_l_r, up_l_nxt;
  logic                     lo_rise_l_r, lo_rise_l_nxt;
  logic                     lo_fall_l_r, lo_fall_l_nxt;
  logic                     last_dir_r, last_dir_nxt;

  // step calculator
  logic [31:0] goal_in;
  logic        sc_differ, sc_down;
  logic [15:0] sc_steps;
  logic        timed_out;

  assign in_stall = s1_valid_r & out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;
  assign s1_adv   = s1_valid_r & ~(out_valid_r & out_stall);

  assign s1_valid_nxt  = in_take | (s1_valid_r & ~s1_adv);
  assign out_valid_nxt = s1_adv | (out_valid_r & out_stall);

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_TIMEOUT: prdata = {16'b0, timeout_r};
      REG_SPEED:   prdata = {16'b0, speed_r};
      default:     prdata = '0;
    endcase
  end

  // a start move takes its new target in the same pass
  assign goal_in = (!s1_r.func && s1_r.cmd == CMD_MOVE_START) ? s1_r.target : goal_r;

  lmp_step_calc u_step_calc (
    .pos    (s1_r.pos),
    .dest   (goal_in),
    .differ (sc_differ),
    .down   (sc_down),
    .steps  (sc_steps)
  );

  assign timed_out = CMP_W'(run_ticks_r) > CMP_W'(timeout_r);

  always_comb begin
    move_ph_nxt   = move_ph_r;
    test_ph_nxt   = test_ph_r;
    move_en_nxt   = move_en_r;
    test_en_nxt   = test_en_r;
    drv_want_nxt  = drv_want_r;
    drv_state_nxt = drv_state_r;
    delay_nxt     = delay_r;
    run_ticks_nxt = run_ticks_r;
    err_nxt       = err_r;
    goal_nxt      = goal_r;
    sampled_nxt   = sampled_r;
    up_l_nxt      = up_l_r;
    lo_rise_l_nxt = lo_rise_l_r;
    lo_fall_l_nxt = lo_fall_l_r;
    last_dir_nxt  = last_dir_r;
    res_nxt       = '0;
    res_nxt.mcmd  = MC_NONE;
    res_nxt.tcmd  = TC_NONE;
    res_nxt.dir   = last_dir_r;

    if (s1_r.func) begin
      if (delay_r != '0) delay_nxt = delay_r - 8'd1;
      if (test_ph_r != TS_IDLE && run_ticks_r != {RUN_TICK_BITS{1'b1}}) begin
        run_ticks_nxt = run_ticks_r + RUN_TICK_BITS'(1);
      end
      sampled_nxt = s1_r.pos;
    end else begin
      case (s1_r.cmd)
        CMD_MOVE_START: begin
          move_en_nxt = 1'b1;
          goal_nxt    = s1_r.target;
        end
        CMD_MOVE_STOP:  move_en_nxt  = 1'b0;
        CMD_TEST_START: test_en_nxt  = 1'b1;
        CMD_TEST_STOP:  test_en_nxt  = 1'b0;
        CMD_DRV_ON:     drv_want_nxt = 1'b1;
        CMD_DRV_OFF:    drv_want_nxt = 1'b0;
        default: ;
      endcase
      up_l_nxt      = up_l_r | s1_r.up_rise;
      lo_rise_l_nxt = lo_rise_l_r | s1_r.low_rise;
      lo_fall_l_nxt = lo_fall_l_r | s1_r.low_fall;
      drv_state_nxt = drv_want_nxt;

      // positioned move, only while no test runs
      if (!test_en_nxt) begin
        if (!move_en_nxt && move_ph_r == MV_IDLE) begin
          if (lo_rise_l_nxt) begin
            lo_rise_l_nxt = 1'b0;
            res_nxt.clr   = 1'b1;
          end
        end else if (!move_en_nxt) begin
          move_ph_nxt  = MV_IDLE;
          res_nxt.mcmd = MC_STOP;
        end else begin
          case (move_ph_r)
            MV_IDLE: begin
              if (sc_differ) begin
                res_nxt.steps = sc_steps;
                res_nxt.dir   = sc_down;
                res_nxt.mcmd  = MC_MOVE;
              end
              move_ph_nxt = MV_MOVING;
            end
            MV_MOVING: begin
              if (!s1_r.running) begin
                err_nxt     = s1_r.fault ? ERR_STALL : ERR_NONE;
                move_ph_nxt = MV_SETTLE;
              end
              if (s1_r.up_level || s1_r.low_level) begin
                res_nxt.mcmd = MC_STOP;
                move_ph_nxt  = MV_SETTLE;
                err_nxt      = ERR_LIMIT;
              end
              delay_nxt = DLY_SHORT;
            end
            MV_SETTLE: begin
              if (delay_r == '0 && s1_r.szero) begin
                move_en_nxt = 1'b0;
                move_ph_nxt = MV_IDLE;
              end
            end
            default: ;
          endcase
        end
      end

      // homing and self-test
      if (!test_en_nxt) begin
        if (test_ph_r != TS_IDLE) begin
          test_ph_nxt  = TS_IDLE;
          res_nxt.tcmd = TC_STOP;
        end
      end else begin
        case (test_ph_r)
          TS_IDLE: begin
            delay_nxt   = DLY_SHORT;
            test_ph_nxt = TS_WAIT;
          end
          TS_WAIT: begin
            if (delay_r == '0) begin
              res_nxt.tcmd = TC_FAST;
              if (s1_r.up_level) begin
                last_dir_nxt = DIR_DOWN;
                test_ph_nxt  = TS_DOWN;
              end else begin
                last_dir_nxt = DIR_UP;
                test_ph_nxt  = TS_UP;
              end
              res_nxt.dir   = last_dir_nxt;
              run_ticks_nxt = '0;
              up_l_nxt      = 1'b0;
              lo_rise_l_nxt = 1'b0;
            end
          end
          TS_UP, TS_DOWN, TS_SLOW: begin
            if (test_ph_r == TS_UP && up_l_nxt) begin
              up_l_nxt     = 1'b0;
              res_nxt.tcmd = TC_STOP;
              delay_nxt    = DLY_LONG;
              test_ph_nxt  = TS_WAIT;
            end else if (test_ph_r == TS_DOWN && lo_rise_l_nxt) begin
              lo_rise_l_nxt = 1'b0;
              res_nxt.clr   = 1'b1;
              res_nxt.tcmd  = TC_STOP;
              delay_nxt     = DLY_LONG;
              test_ph_nxt   = TS_HOLD;
            end else if (test_ph_r == TS_SLOW && lo_fall_l_nxt) begin
              lo_fall_l_nxt = 1'b0;
              res_nxt.tcmd  = TC_STOP;
              delay_nxt     = DLY_LONG;
              test_ph_nxt   = TS_DONE;
            end else if (!s1_r.running) begin
              if (s1_r.fault) begin
                err_nxt     = ERR_STALL;
                test_ph_nxt = TS_IDLE;
                test_en_nxt = 1'b0;
              end else begin
                test_ph_nxt = (test_ph_r == TS_SLOW) ? TS_DONE : TS_WAIT;
              end
            end else if (timed_out) begin
              res_nxt.tcmd = TC_STOP;
              err_nxt      = ERR_TIMEOUT;
              test_ph_nxt  = TS_IDLE;
              test_en_nxt  = 1'b0;
            end
          end
          TS_HOLD: begin
            if (delay_r == '0) begin
              res_nxt.tcmd  = TC_SLOW;
              last_dir_nxt  = DIR_UP;
              res_nxt.dir   = DIR_UP;
              test_ph_nxt   = TS_SLOW;
              run_ticks_nxt = '0;
              lo_fall_l_nxt = 1'b0;
            end
          end
          TS_DONE: begin
            if (delay_r == '0) begin
              test_en_nxt = 1'b0;
              test_ph_nxt = TS_IDLE;
            end
          end
          default: ;
        endcase
      end
    end

    res_nxt.drv    = drv_state_nxt;
    res_nxt.mstate = move_code(move_ph_nxt);
    res_nxt.tstate = test_code(test_ph_nxt);
    res_nxt.err    = err_nxt;
    res_nxt.pos    = sampled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      speed_r     <= SPEED_RST;
      move_ph_r   <= MV_IDLE;
      test_ph_r   <= TS_IDLE;
      move_en_r   <= 1'b0;
      test_en_r   <= 1'b0;
      drv_want_r  <= 1'b0;
      drv_state_r <= 1'b0;
      delay_r     <= '0;
      run_ticks_r <= '0;
      err_r       <= ERR_NONE;
      goal_r      <= '0;
      sampled_r   <= '0;
      up_l_r      <= 1'b0;
      lo_rise_l_r <= 1'b0;
      lo_fall_l_r <= 1'b0;
      last_dir_r  <= DIR_DOWN;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && paddr[2] == REG_TIMEOUT) timeout_r <= pwdata[15:0];
      if (cfg_wr && paddr[2] == REG_SPEED)   speed_r   <= pwdata[15:0];
      if (s1_adv) begin
        move_ph_r   <= move_ph_nxt;
        test_ph_r   <= test_ph_nxt;
        move_en_r   <= move_en_nxt;
        test_en_r   <= test_en_nxt;
        drv_want_r  <= drv_want_nxt;
        drv_state_r <= drv_state_nxt;
        delay_r     <= delay_nxt;
        run_ticks_r <= run_ticks_nxt;
        err_r       <= err_nxt;
        goal_r      <= goal_nxt;
        sampled_r   <= sampled_nxt;
        up_l_r      <= up_l_nxt;
        lo_rise_l_r <= lo_rise_l_nxt;
        lo_fall_l_r <= lo_fall_l_nxt;
        last_dir_r  <= last_dir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.func      <= in_func;
      s1_r.up_level  <= in_up_level;
      s1_r.up_rise   <= in_up_rise;
      s1_r.low_level <= in_low_level;
      s1_r.low_rise  <= in_low_rise;
      s1_r.low_fall  <= in_low_fall;
      s1_r.running   <= in_motor_running;
      s1_r.fault     <= in_motor_fault;
      s1_r.pos       <= in_encoder_pos;
      s1_r.szero     <= in_speed_zero;
      s1_r.cmd       <= in_command;
      s1_r.target    <= in_target_pos;
    end
    if (s1_adv) res_r <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_move_cmd        = res_r.mcmd;
  assign out_test_cmd        = res_r.tcmd;
  assign out_direction       = res_r.dir;
  assign out_step_count      = res_r.steps;
  assign out_encoder_clear   = res_r.clr;
  assign out_driver_on       = res_r.drv;
  assign out_move_state      = res_r.mstate;
  assign out_test_state      = res_r.tstate;
  assign out_error_code      = res_r.err;
  assign out_position_report = res_r.pos;

endmodule

// File: design/lmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmp_checker
// Port-level checks of the lift motor sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "lift_motor_position_and_homing_sequencer_macros.svh"

module lmp_checker
  import lmp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_move_cmd,
  input logic [1:0]  out_move_state,
  input logic [15:0] out_step_count,
  input logic        out_encoder_clear
);

  `LMP_ASSERT_NXT_RST(a_rst_empty, !rst_n, !out_valid, "result valid after reset")
  `LMP_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")
  `LMP_ASSERT_IMP(a_move_phase, out_valid && out_move_cmd == MC_MOVE, out_move_state == MS_MOVING, "move issued outside moving phase")
  `LMP_ASSERT_IMP(a_steps_move, out_valid && out_step_count != 16'd0, out_move_cmd == MC_MOVE, "step count without move")
  `LMP_ASSERT_IMP(a_clr_nomove, out_valid && out_encoder_clear, out_move_cmd == MC_NONE, "encoder clear with move command")

endmodule

bind lift_motor_position_and_homing_sequencer lmp_checker u_lmp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_move_cmd      (out_move_cmd),
  .out_move_state    (out_move_state),
  .out_step_count    (out_step_count),
  .out_encoder_clear (out_encoder_clear)
);

// File: verif/lift_motor_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lift_motor_status_checker
// Watches the input, result and register ports of the lift motor sequencer,
// predicts the status word for every accepted input word and compares each
// accepted result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module lift_motor_status_checker
  import lmp_pkg::*;
#(
  parameter int         RUN_TICK_BITS = 16,
  parameter logic [2:0] TIMEOUT_ADDR  = 3'd0,
  parameter logic [2:0] SPEED_ADDR    = 3'd4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_func,
  input  logic               in_up_level,
  input  logic               in_up_rise,
  input  logic               in_low_level,
  input  logic               in_low_rise,
  input  logic               in_low_fall,
  input  logic               in_motor_running,
  input  logic               in_motor_fault,
  input  logic signed [31:0] in_encoder_pos,
  input  logic               in_speed_zero,
  input  logic        [2:0]  in_command,
  input  logic signed [31:0] in_target_pos,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic        [1:0]  out_move_cmd,
  input  logic        [1:0]  out_test_cmd,
  input  logic               out_direction,
  input  logic        [15:0] out_step_count,
  input  logic               out_encoder_clear,
  input  logic               out_driver_on,
  input  logic        [1:0]  out_move_state,
  input  logic        [2:0]  out_test_state,
  input  logic        [1:0]  out_error_code,
  input  logic signed [31:0] out_position_report,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  // homing and self-test sequence steps
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_WAIT = 3'd1;
  localparam logic [2:0] PH_UP   = 3'd2;
  localparam logic [2:0] PH_DOWN = 3'd3;
  localparam logic [2:0] PH_HOLD = 3'd4;
  localparam logic [2:0] PH_SLOW = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  localparam logic [RUN_TICK_BITS-1:0] RUN_MAX = '1;

  typedef struct packed {
    logic [1:0]  move_cmd;
    logic [1:0]  test_cmd;
    logic        direction;
    logic [15:0] step_count;
    logic        encoder_clear;
    logic        driver_on;
    logic [1:0]  move_state;
    logic [2:0]  test_state;
    logic [1:0]  error_code;
    logic [31:0] position;
  } lift_status_t;

  lift_status_t status_q[$];

  logic [15:0]              timeout_ticks;
  logic [15:0]              test_speed;
  logic [1:0]               move_phase;
  logic [2:0]               test_phase;
  logic                     move_en, test_en, drv_want, drv_state;
  logic [7:0]               delay_left;
  logic [RUN_TICK_BITS-1:0] run_ticks;
  logic [1:0]               err_reg, test_err;
  logic signed [31:0]       goal_pos;
  logic [31:0]              sampled_pos;
  logic                     up_rise_l, low_rise_l, low_fall_l;
  logic [1:0]               limits;
  logic                     last_dir;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic reset_supervisor();
    timeout_ticks = TIMEOUT_RST;
    test_speed    = SPEED_RST;
    move_phase    = MS_IDLE;
    test_phase    = PH_IDLE;
    move_en       = 1'b0;
    test_en       = 1'b0;
    drv_want      = 1'b0;
    drv_state     = 1'b0;
    delay_left    = '0;
    run_ticks     = '0;
    err_reg       = ERR_NONE;
    test_err      = ERR_NONE;
    goal_pos      = '0;
    sampled_pos   = '0;
    up_rise_l     = 1'b0;
    low_rise_l    = 1'b0;
    low_fall_l    = 1'b0;
    limits        = '0;
    last_dir      = DIR_DOWN;
  endtask

  // running test leg that saw no awaited edge: stop, stall or timeout
  task automatic guard_run(input logic [2:0] quiet_next, inout logic [1:0] tcmd);
    if (!in_motor_running) begin
      if (in_motor_fault) begin
        err_reg    = ERR_STALL;
        test_err   = ERR_STALL;
        test_phase = PH_IDLE;
        test_en    = 1'b0;
      end else begin
        test_phase = quiet_next;
      end
    end else if (32'(run_ticks) > 32'(timeout_ticks)) begin
      tcmd       = TC_STOP;
      test_err   = ERR_TIMEOUT;
      err_reg    = ERR_TIMEOUT;
      test_phase = PH_IDLE;
      test_en    = 1'b0;
    end
  endtask

  task automatic step_supervisor(output lift_status_t st);
    logic [1:0]         mcmd, tcmd;
    logic               dir, clr;
    logic [15:0]        steps;
    logic signed [32:0] diff;
    logic [32:0]        span;
    logic [39:0]        scaled;
    mcmd  = MC_NONE;
    tcmd  = TC_NONE;
    dir   = last_dir;
    steps = '0;
    clr   = 1'b0;
    if (in_func) begin
      if (delay_left != 0) delay_left = delay_left - 8'd1;
      if (test_phase != PH_IDLE && run_ticks != RUN_MAX) begin
        run_ticks = run_ticks + RUN_TICK_BITS'(1);
      end
      sampled_pos = in_encoder_pos;
    end else begin
      case (in_command)
        CMD_MOVE_START: begin
          move_en  = 1'b1;
          goal_pos = in_target_pos;
        end
        CMD_MOVE_STOP:  move_en  = 1'b0;
        CMD_TEST_START: test_en  = 1'b1;
        CMD_TEST_STOP:  test_en  = 1'b0;
        CMD_DRV_ON:     drv_want = 1'b1;
        CMD_DRV_OFF:    drv_want = 1'b0;
        default: ;
      endcase
      up_rise_l  = up_rise_l | in_up_rise;
      low_rise_l = low_rise_l | in_low_rise;
      low_fall_l = low_fall_l | in_low_fall;
      limits     = {in_low_level, in_up_level};
      drv_state  = drv_want;

      if (!test_en) begin
        if (!move_en && move_phase == MS_IDLE) begin
          if (low_rise_l) begin
            low_rise_l = 1'b0;
            clr        = 1'b1;
          end
        end else if (!move_en) begin
          move_phase = MS_IDLE;
          mcmd       = MC_STOP;
        end else if (move_phase == MS_IDLE) begin
          if (in_encoder_pos != goal_pos) begin
            diff   = {in_encoder_pos[31], in_encoder_pos} - {goal_pos[31], goal_pos};
            span   = diff[32] ? -diff : diff;
            scaled = ({7'd0, span} * 40'd25) >> 6;
            steps  = (scaled > 40'hFFFF) ? 16'hFFFF : scaled[15:0];
            dir    = (in_encoder_pos > goal_pos) ? DIR_DOWN : DIR_UP;
            mcmd   = MC_MOVE;
          end
          move_phase = MS_MOVING;
        end else if (move_phase == MS_MOVING) begin
          if (!in_motor_running) begin
            err_reg    = in_motor_fault ? ERR_STALL : ERR_NONE;
            move_phase = MS_SETTLE;
          end
          if (limits != 2'b00) begin
            mcmd       = MC_STOP;
            move_phase = MS_SETTLE;
            err_reg    = ERR_LIMIT;
          end
          delay_left = DLY_SHORT;
        end else if (move_phase == MS_SETTLE) begin
          if (delay_left == 0 && in_speed_zero) begin
            move_en    = 1'b0;
            move_phase = MS_IDLE;
          end
        end
      end

      if (!test_en) begin
        if (test_phase != PH_IDLE) begin
          test_phase = PH_IDLE;
          tcmd       = TC_STOP;
        end
      end else begin
        case (test_phase)
          PH_IDLE: begin
            delay_left = DLY_SHORT;
            test_phase = PH_WAIT;
          end
          PH_WAIT: begin
            if (delay_left == 0) begin
              tcmd = TC_FAST;
              if (limits[0]) begin
                last_dir   = DIR_DOWN;
                test_phase = PH_DOWN;
              end else begin
                last_dir   = DIR_UP;
                test_phase = PH_UP;
              end
              dir        = last_dir;
              run_ticks  = '0;
              up_rise_l  = 1'b0;
              low_rise_l = 1'b0;
            end
          end
          PH_UP: begin
            if (up_rise_l) begin
              up_rise_l  = 1'b0;
              tcmd       = TC_STOP;
              delay_left = DLY_LONG;
              test_phase = PH_WAIT;
            end else begin
              guard_run(PH_WAIT, tcmd);
            end
          end
          PH_DOWN: begin
            if (low_rise_l) begin
              low_rise_l = 1'b0;
              clr        = 1'b1;
              tcmd       = TC_STOP;
              delay_left = DLY_LONG;
              test_phase = PH_HOLD;
            end else begin
              guard_run(PH_WAIT, tcmd);
            end
          end
          PH_HOLD: begin
            if (delay_left == 0) begin
              tcmd       = TC_SLOW;
              last_dir   = DIR_UP;
              dir        = DIR_UP;
              test_phase = PH_SLOW;
              run_ticks  = '0;
              low_fall_l = 1'b0;
            end
          end
          PH_SLOW: begin
            if (low_fall_l) begin
              low_fall_l = 1'b0;
              tcmd       = TC_STOP;
              delay_left = DLY_LONG;
              test_phase = PH_DONE;
            end else begin
              guard_run(PH_DONE, tcmd);
            end
          end
          PH_DONE: begin
            if (delay_left == 0) begin
              test_en    = 1'b0;
              test_phase = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
    st.move_cmd      = mcmd;
    st.test_cmd      = tcmd;
    st.direction     = dir;
    st.step_count    = steps;
    st.encoder_clear = clr;
    st.driver_on     = drv_state;
    st.move_state    = move_phase;
    st.test_state    = test_phase;
    st.error_code    = err_reg;
    st.position      = sampled_pos;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (act !== exp) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lift_status_t st;
    if (!rst_n) begin
      reset_supervisor();
      status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          TIMEOUT_ADDR: timeout_ticks = pwdata[15:0];
          SPEED_ADDR:   test_speed    = pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $display("%0t: result word with nothing outstanding", $time);
          fail_count++;
        end else begin
          st = status_q.pop_front();
          check_field("move_cmd", 32'(st.move_cmd), 32'(out_move_cmd));
          check_field("test_cmd", 32'(st.test_cmd), 32'(out_test_cmd));
          check_field("direction", 32'(st.direction), 32'(out_direction));
          check_field("step_count", 32'(st.step_count), 32'(out_step_count));
          check_field("encoder_clear", 32'(st.encoder_clear), 32'(out_encoder_clear));
          check_field("driver_on", 32'(st.driver_on), 32'(out_driver_on));
          check_field("move_state", 32'(st.move_state), 32'(out_move_state));
          check_field("test_state", 32'(st.test_state), 32'(out_test_state));
          check_field("error_code", 32'(st.error_code), 32'(out_error_code));
          check_field("position_report", st.position, out_position_report);
        end
      end
      if (in_valid && !in_stall) begin
        step_supervisor(st);
        status_q.push_back(st);
      end
    end
    pending = status_q.size();
  end

endmodule

// File: verif/lift_motor_position_and_homing_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lift_motor_position_and_homing_sequencer_test
// Drives control and tick words into the lift motor sequencer: a directed
// opening, then positioned moves, homing runs and noise over several
// register settings, with random idling, a long receiver hold-off and a
// run-time saturation soak. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module lift_motor_position_and_homing_sequencer_test;
  import lmp_pkg::*;

  // narrow run-time counter so that the soak reaches saturation quickly
  localparam int         RUN_TICK_BITS    = 8;
  localparam logic [2:0] REG_TIMEOUT_ADDR = 3'd0;
  localparam logic [2:0] REG_SPEED_ADDR   = 3'd4;
  localparam logic [2:0] CMD_RESERVED     = 3'd7;
  localparam int         HOLD_CYCLES      = 300;
  localparam int         STALL_LIMIT      = 3000;
  localparam int         PHASE_WORDS      = 280;

  typedef enum {AWAIT_UP_RISE, AWAIT_LOW_RISE, AWAIT_LOW_FALL} await_t;

  typedef struct {
    logic        func;
    logic        up_lv;
    logic        up_rise;
    logic        lo_lv;
    logic        lo_rise;
    logic        lo_fall;
    logic        running;
    logic        fault;
    logic [31:0] pos;
    logic        szero;
    logic [2:0]  cmd;
    logic [31:0] target;
  } lift_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid, in_stall;
  logic               in_func, in_up_level, in_up_rise, in_low_level;
  logic               in_low_rise, in_low_fall, in_motor_running, in_motor_fault;
  logic signed [31:0] in_encoder_pos;
  logic               in_speed_zero;
  logic        [2:0]  in_command;
  logic signed [31:0] in_target_pos;
  logic               out_valid, out_stall;
  logic        [1:0]  out_move_cmd, out_test_cmd;
  logic               out_direction;
  logic        [15:0] out_step_count;
  logic               out_encoder_clear, out_driver_on;
  logic        [1:0]  out_move_state;
  logic        [2:0]  out_test_state;
  logic        [1:0]  out_error_code;
  logic signed [31:0] out_position_report;
  logic               psel, penable, pwrite;
  logic        [2:0]  paddr;
  logic        [31:0] pwdata, prdata;
  logic               pready;

  int                 fail_count, pending;
  int                 words_sent = 0;
  int                 in_idle_pct = 10;
  int                 out_idle_pct = 10;
  logic               hold_go;
  logic signed [31:0] lift_pos = 32'sd1000;

  lift_motor_position_and_homing_sequencer #(.RUN_TICK_BITS(RUN_TICK_BITS)) u_dut (.*);

  lift_motor_status_checker #(
    .RUN_TICK_BITS (RUN_TICK_BITS),
    .TIMEOUT_ADDR  (REG_TIMEOUT_ADDR),
    .SPEED_ADDR    (REG_SPEED_ADDR)
  ) u_check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic lift_word_t noise_word();
    lift_word_t w;
    w.func    = 1'($urandom_range(0, 1));
    w.up_lv   = 1'($urandom_range(0, 1));
    w.up_rise = 1'($urandom_range(0, 1));
    w.lo_lv   = 1'($urandom_range(0, 1));
    w.lo_rise = 1'($urandom_range(0, 1));
    w.lo_fall = 1'($urandom_range(0, 1));
    w.running = 1'($urandom_range(0, 1));
    w.fault   = 1'($urandom_range(0, 1));
    w.pos     = $urandom;
    w.szero   = 1'($urandom_range(0, 1));
    w.cmd     = 3'($urandom_range(0, 7));
    w.target  = $urandom;
    return w;
  endfunction

  function automatic lift_word_t tick_word();
    lift_word_t w;
    w      = noise_word();
    w.func = 1'b1;
    if ($urandom_range(0, 3) != 0) w.pos = lift_pos;
    return w;
  endfunction

  // control pass with a running motor and nothing else going on
  function automatic lift_word_t quiet_pass();
    lift_word_t w;
    lift_pos  = lift_pos + 32'($urandom_range(0, 200)) - 32'sd100;
    w.func    = 1'b0;
    w.up_lv   = 1'b0;
    w.up_rise = 1'b0;
    w.lo_lv   = 1'b0;
    w.lo_rise = 1'b0;
    w.lo_fall = 1'b0;
    w.running = 1'b1;
    w.fault   = 1'b0;
    w.pos     = lift_pos;
    w.szero   = 1'b0;
    w.cmd     = CMD_NONE;
    w.target  = $urandom;
    return w;
  endfunction

  task automatic send(input lift_word_t w);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= w.func;
    in_up_level      <= w.up_lv;
    in_up_rise       <= w.up_rise;
    in_low_level     <= w.lo_lv;
    in_low_rise      <= w.lo_rise;
    in_low_fall      <= w.lo_fall;
    in_motor_running <= w.running;
    in_motor_fault   <= w.fault;
    in_encoder_pos   <= w.pos;
    in_speed_zero    <= w.szero;
    in_command       <= w.cmd;
    in_target_pos    <= w.target;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_cmd(input logic [2:0] cmd);
    lift_word_t w;
    w     = quiet_pass();
    w.cmd = cmd;
    send(w);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send(tick_word());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_words();
    lift_word_t w;
    w = tick_word(); w.pos = 32'h7FFF_FFFF; send(w);
    w = tick_word(); w.pos = 32'h8000_0000; send(w);
    send_cmd(CMD_RESERVED);
    send_cmd(CMD_DRV_ON);
    w = quiet_pass(); w.lo_rise = 1'b1; send(w);
    send_cmd(CMD_DRV_OFF);
    // widest spans both ways, saturating the step count
    w = quiet_pass(); w.pos = 32'h7FFF_FFFF; w.target = 32'h8000_0000;
    w.cmd = CMD_MOVE_START; send(w);
    send_cmd(CMD_MOVE_STOP);
    w = quiet_pass(); w.pos = 32'h8000_0000; w.target = 32'h7FFF_FFFF;
    w.cmd = CMD_MOVE_START; send(w);
    w = quiet_pass(); w.running = 1'b0; w.fault = 1'b1; send(w);
    send_ticks(6);
    w = quiet_pass(); w.szero = 1'b1; send(w);
    // already on target, then both limits hit
    w = quiet_pass(); w.pos = '0; w.target = '0; w.cmd = CMD_MOVE_START; send(w);
    w = quiet_pass(); w.up_lv = 1'b1; w.lo_lv = 1'b1; send(w);
    send_ticks(5);
    w = quiet_pass(); w.szero = 1'b1; send(w);
    w = quiet_pass(); w.pos = '0; w.target = 32'd64; w.cmd = CMD_MOVE_START; send(w);
    send_cmd(CMD_MOVE_STOP);
    send_cmd(CMD_TEST_START);
    send_ticks(2);
    send_cmd(CMD_TEST_STOP);
  endtask

  task automatic run_move();
    lift_word_t w;
    send_cmd(CMD_TEST_STOP);
    w     = quiet_pass();
    w.cmd = CMD_MOVE_START;
    case ($urandom_range(0, 9))
      0:       w.target = w.pos;
      1:       w.target = $urandom;
      2:       w.target = w.pos + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1) *
                          32'($urandom_range(200000, 400000));
      default: w.target = w.pos + 32'($urandom_range(0, 40000)) - 32'sd20000;
    endcase
    send(w);
    repeat ($urandom_range(0, 3)) begin
      send_ticks($urandom_range(0, 2));
      w = quiet_pass();
      if ($urandom_range(0, 7) == 0) w.up_lv = 1'b1;
      if ($urandom_range(0, 7) == 0) w.lo_lv = 1'b1;
      send(w);
    end
    if ($urandom_range(0, 5) == 0) begin
      send_cmd(CMD_MOVE_STOP);
      return;
    end
    w = quiet_pass(); w.running = 1'b0; w.fault = ($urandom_range(0, 4) == 0); send(w);
    repeat ($urandom_range(0, 3)) begin
      send_ticks($urandom_range(0, 3));
      w = quiet_pass(); w.running = 1'b0; w.szero = 1'($urandom_range(0, 1)); send(w);
    end
    send_ticks(5);
    w = quiet_pass(); w.running = 1'b0; w.szero = 1'b1;
    w.lo_rise = 1'($urandom_range(0, 1)); send(w);
  endtask

  // one running leg of the homing run; ok is low once the sequence is off track
  task automatic run_leg(input await_t awaited, output bit ok);
    lift_word_t w;
    int         pick;
    ok = 1'b0;
    repeat ($urandom_range(0, 3)) begin
      send_ticks($urandom_range(0, 3));
      w = quiet_pass();
      w.up_rise = (awaited != AWAIT_UP_RISE) && ($urandom_range(0, 7) == 0);
      w.lo_rise = (awaited != AWAIT_LOW_RISE) && ($urandom_range(0, 7) == 0);
      w.lo_fall = (awaited != AWAIT_LOW_FALL) && ($urandom_range(0, 7) == 0);
      send(w);
    end
    pick = $urandom_range(0, 19);
    w    = quiet_pass();
    if (pick == 0) begin
      w.running = 1'b0; w.fault = 1'b1; send(w);
    end else if (pick == 1) begin
      w.running = 1'b0; send(w);
    end else if (pick == 2) begin
      send_cmd(CMD_TEST_STOP);
    end else begin
      case (awaited)
        AWAIT_UP_RISE:  w.up_rise = 1'b1;
        AWAIT_LOW_RISE: w.lo_rise = 1'b1;
        default:        w.lo_fall = 1'b1;
      endcase
      send(w);
      ok = 1'b1;
    end
  endtask

  task automatic run_homing();
    lift_word_t w;
    bit         ok;
    bit         at_top;
    send_cmd(CMD_TEST_STOP);
    send_cmd(CMD_TEST_START);
    send_ticks($urandom_range(5, 7));
    at_top  = ($urandom_range(0, 3) == 0);
    w       = quiet_pass();
    w.up_lv = at_top;
    send(w);
    if (!at_top) begin
      run_leg(AWAIT_UP_RISE, ok);
      if (!ok) return;
      send_ticks($urandom_range(50, 52));
      w = quiet_pass(); w.up_lv = 1'b1; send(w);
    end
    run_leg(AWAIT_LOW_RISE, ok);
    if (!ok) return;
    send_ticks($urandom_range(50, 52));
    send(quiet_pass());
    run_leg(AWAIT_LOW_FALL, ok);
    if (!ok) return;
    send_ticks($urandom_range(50, 52));
    send(quiet_pass());
  endtask

  // run-time counter driven into saturation on an endless up run
  task automatic run_soak();
    lift_word_t w;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_cmd(CMD_TEST_STOP);
    send_cmd(CMD_TEST_START);
    send_ticks(6);
    send(quiet_pass());
    send_ticks(300);
    w = quiet_pass();
    send(w);
    send_cmd(CMD_TEST_STOP);
    in_idle_pct  = 10;
    out_idle_pct = 10;
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("lift_motor_position_and_homing_sequencer: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] timeout_set [6];
    logic [15:0] speed_set [6];
    int          goal_words;
    timeout_set = '{16'd3000, 16'd0, 16'hFFFF, 16'd4, 16'd25, 16'd3000};
    speed_set   = '{16'd300, 16'd0, 16'hFFFF, 16'd1, 16'd7000, 16'd300};
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_func          <= 1'b0;
    in_up_level      <= 1'b0;
    in_up_rise       <= 1'b0;
    in_low_level     <= 1'b0;
    in_low_rise      <= 1'b0;
    in_low_fall      <= 1'b0;
    in_motor_running <= 1'b0;
    in_motor_fault   <= 1'b0;
    in_encoder_pos   <= '0;
    in_speed_zero    <= 1'b0;
    in_command       <= CMD_NONE;
    in_target_pos    <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= REG_TIMEOUT_ADDR;
    pwdata           <= '0;
    hold_go          <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        drain();
        write_reg(REG_TIMEOUT_ADDR, {16'($urandom), timeout_set[ph]});
        write_reg(REG_SPEED_ADDR, {16'($urandom), speed_set[ph]});
      end
      if (ph == 2) run_soak();
      if (ph == 3) begin
        hold_go    <= 1'b1;
        in_idle_pct = 0;
      end else begin
        in_idle_pct = 10;
      end
      goal_words = words_sent + PHASE_WORDS;
      while (words_sent < goal_words) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: run_homing();
          4, 5, 6:    run_move();
          7:          send_cmd($urandom_range(0, 1) ? CMD_DRV_ON : CMD_DRV_OFF);
          default:    repeat ($urandom_range(1, 8)) send(noise_word());
        endcase
      end
    end

    drain();
    @(negedge clk);
    if (fail_count == 0)
      $display("lift_motor_position_and_homing_sequencer: match");
    else
      $display("lift_motor_position_and_homing_sequencer: mismatch");
    $finish;
  end

endmodule
